// ===== src/deque_with_value_removal_assert.svh =====
// Assertion macros for the deque block
`ifndef DEQUE_WITH_VALUE_REMOVAL_ASSERT_SVH
`define DEQUE_WITH_VALUE_REMOVAL_ASSERT_SVH

// Same-cycle implication under reset
`define DQVR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque assertion failed");

// Next-cycle implication under reset
`define DQVR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque assertion failed");

`endif

// ===== src/dqvr_pkg.sv =====
// Shared types, constants and helpers of the deque block
package dqvr_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KIND_W   = 3;
    localparam int VAL_W    = 32;
    localparam int RC_W     = 7;

    typedef enum logic [KIND_W-1:0] {
        K_PUSH_FRONT = 3'd0,
        K_PUSH_BACK  = 3'd1,
        K_POP_FRONT  = 3'd2,
        K_POP_BACK   = 3'd3,
        K_CLEAR      = 3'd4,
        K_REMOVE     = 3'd5,
        K_READ_FIRST = 3'd6,
        K_READ_LAST  = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_NODATA = 2'd3
    } t_status;

    typedef struct packed {
        logic signed [VAL_W-1:0] item_value;
        logic                    last_of_run;
        t_status                 status;
        logic [RC_W-1:0]         entry_count;
    } t_rsp;

    typedef struct packed {
        logic load;
        logic setup;
        logic walk;
        logic commit;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic walk_done;
        logic rd_none;
        logic kind_rd;
        logic kind_rmv;
    } t_sts;

    function automatic logic [IDX_W-1:0] f_ring(input logic [CNT_W:0] pos);
        logic [CNT_W:0] p;
        p = pos;
        if (p >= (CNT_W+1)'(CAPACITY)) begin
            p = p - (CNT_W+1)'(CAPACITY);
        end
        return p[IDX_W-1:0];
    endfunction

endpackage

// ===== src/dqvr_if.sv =====
// Request and response channel interfaces of the deque block
interface dqvr_in_if import dqvr_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [KIND_W-1:0]       kind;
    logic signed [VAL_W-1:0] value;
    logic [RC_W-1:0]         read_count;

    modport source (output valid, kind, value, read_count, input ready);
    modport sink   (input valid, kind, value, read_count, output ready);
endinterface

interface dqvr_out_if import dqvr_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] item_value;
    logic                    last_of_run;
    logic [1:0]              status;
    logic [RC_W-1:0]         entry_count;

    modport source (output valid, item_value, last_of_run, status, entry_count, input ready);
    modport sink   (input valid, item_value, last_of_run, status, entry_count, output ready);
endinterface

// ===== src/dqvr_datapath.sv =====
// Datapath of the deque: ring store, pointers, walk counters, result register
module dqvr_datapath import dqvr_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_sts                    o_sts,
    input  logic [KIND_W-1:0]       i_kind,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic [RC_W-1:0]         i_read_count,
    input  logic                    i_out_ready,
    output t_rsp                    o_rsp,
    output logic                    o_out_valid
);

    logic signed [VAL_W-1:0] r_mem [CAPACITY];

    t_kind                   r_kind;
    logic signed [VAL_W-1:0] r_value;
    logic [RC_W-1:0]         r_want;
    logic [IDX_W-1:0]        r_front, n_front;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [CNT_W-1:0]        r_walk, r_left, r_kept;
    logic signed [VAL_W-1:0] r_rdata;
    logic                    r_rd_vld, r_rd_last;
    t_rsp                    r_out;
    logic                    r_out_vld;

    logic                    is_rd, is_rmv, full, empty, out_free;
    logic                    mv, issue, keep, emit_go;
    logic [RC_W-1:0]         count_ext;
    logic [CNT_W-1:0]        rd_n, rd_start;
    logic [IDX_W-1:0]        rd_addr, front_dec, front_inc;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic signed [VAL_W-1:0] wr_data;
    t_status                 st;

    assign is_rd     = (r_kind == K_READ_FIRST) || (r_kind == K_READ_LAST);
    assign is_rmv    = (r_kind == K_REMOVE);
    assign full      = (r_count == CNT_W'(CAPACITY));
    assign empty     = (r_count == '0);
    assign count_ext = RC_W'(r_count);
    assign rd_n      = (r_want < count_ext) ? CNT_W'(r_want) : r_count;
    assign rd_start  = (r_kind == K_READ_FIRST) ? '0 : (r_count - rd_n);
    assign out_free  = !r_out_vld || i_out_ready;
    assign mv        = i_cmd.walk && r_rd_vld && (is_rmv || out_free);
    assign issue     = i_cmd.walk && (r_left != '0) && (!r_rd_vld || mv);
    assign rd_addr   = f_ring((CNT_W+1)'(r_front) + (CNT_W+1)'(r_walk));
    assign keep      = mv && is_rmv && (r_rdata != r_value);
    assign emit_go   = i_cmd.emit && out_free;
    assign front_dec = (r_front == '0) ? IDX_W'(CAPACITY - 1) : (r_front - 1'b1);
    assign front_inc = (r_front == IDX_W'(CAPACITY - 1)) ? '0 : (r_front + 1'b1);

    always_comb begin
        n_front = r_front;
        n_count = r_count;
        st      = ST_OK;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = r_value;
        if (emit_go) begin
            case (r_kind)
                K_PUSH_FRONT: begin
                    if (full) begin
                        st = ST_FULL;
                    end else begin
                        n_front = front_dec;
                        wr_en   = 1'b1;
                        wr_addr = front_dec;
                        n_count = r_count + 1'b1;
                    end
                end
                K_PUSH_BACK: begin
                    if (full) begin
                        st = ST_FULL;
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = f_ring((CNT_W+1)'(r_front) + (CNT_W+1)'(r_count));
                        n_count = r_count + 1'b1;
                    end
                end
                K_POP_FRONT: begin
                    if (empty) begin
                        st = ST_EMPTY;
                    end else begin
                        n_front = front_inc;
                        n_count = r_count - 1'b1;
                    end
                end
                K_POP_BACK: begin
                    if (empty) begin
                        st = ST_EMPTY;
                    end else begin
                        n_count = r_count - 1'b1;
                    end
                end
                K_CLEAR: begin
                    n_count = '0;
                end
                K_REMOVE: begin
                    st = ST_OK;
                end
                default: begin
                    st = ST_NODATA;
                end
            endcase
        end
        if (i_cmd.commit) begin
            n_count = r_kept;
        end
        if (keep) begin
            wr_en   = 1'b1;
            wr_addr = f_ring((CNT_W+1)'(r_front) + (CNT_W+1)'(r_kept));
            wr_data = r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (issue) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front   <= '0;
            r_count   <= '0;
            r_left    <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_front  <= n_front;
            r_count  <= n_count;
            r_rd_vld <= issue || (r_rd_vld && !mv);
            if (i_cmd.setup) begin
                r_left <= is_rd ? rd_n : r_count;
            end else if (issue) begin
                r_left <= r_left - 1'b1;
            end
            if (emit_go || (mv && is_rd)) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= t_kind'(i_kind);
            r_value <= i_value;
            r_want  <= i_read_count;
        end
        if (i_cmd.setup) begin
            r_walk <= is_rd ? rd_start : '0;
            r_kept <= '0;
        end else begin
            if (issue) begin
                r_walk    <= r_walk + 1'b1;
                r_rd_last <= (r_left == CNT_W'(1));
            end
            if (keep) begin
                r_kept <= r_kept + 1'b1;
            end
        end
        if (emit_go) begin
            r_out <= '{item_value: '0, last_of_run: 1'b1, status: st,
                       entry_count: RC_W'(n_count)};
        end else if (mv && is_rd) begin
            r_out <= '{item_value: r_rdata, last_of_run: r_rd_last, status: ST_OK,
                       entry_count: count_ext};
        end
    end

    assign o_sts.out_free  = out_free;
    assign o_sts.walk_done = (r_left == '0) && !r_rd_vld;
    assign o_sts.rd_none   = (rd_n == '0);
    assign o_sts.kind_rd   = is_rd;
    assign o_sts.kind_rmv  = is_rmv;

    assign o_rsp       = r_out;
    assign o_out_valid = r_out_vld;

endmodule

// ===== src/dqvr_ctrl.sv =====
// Control state machine of the deque: accept, setup, walk and emit sequencing
module dqvr_ctrl import dqvr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [KIND_W-1:0] i_kind,
    input  t_sts              i_sts,
    output logic              o_ready,
    output t_cmd              o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SETUP = 4'b0010,
        S_WALK  = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    t_kind  kind;

    assign kind = t_kind'(i_kind);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    if (kind inside {K_READ_FIRST, K_READ_LAST, K_REMOVE}) begin
                        n_state = S_SETUP;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                if (i_sts.kind_rd && i_sts.rd_none) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_sts.walk_done) begin
                    if (i_sts.kind_rmv) begin
                        o_cmd.commit = 1'b1;
                        n_state      = S_EMIT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== src/deque_with_value_removal.sv =====
// Top level of the bounded deque with value removal
//
//   channel   dir   handshake       payload
//   i_req     in    valid/ready     kind, value, read_count
//   o_rsp     out   valid/ready     item_value, last_of_run, status, entry_count
//
// One request is in flight. Push, pop and clear go from accept to the emit state, which
// registers the result. A read of n entries runs setup, then a walk of them (or goes from
// setup to emit with nothing to give); a removal walks all entries, commits and emits.
// Walks are bounded by the single read port of the ring store, walking one entry per cycle unless o_rsp stalls a read.
// Reset is synchronous; the store is not cleared and needs no sweep.
// A stalled o_rsp holds the read walk; a status result waits in its state.
module deque_with_value_removal import dqvr_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    dqvr_in_if.sink    i_req,
    dqvr_out_if.source o_rsp
);

`include "deque_with_value_removal_assert.svh"

    t_cmd w_cmd;
    t_sts w_sts;
    t_rsp w_rsp;
    logic w_out_valid;
    logic w_in_fire;
    logic w_st_err;
    logic w_st_full;

    dqvr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .i_kind  (i_req.kind),
        .i_sts   (w_sts),
        .o_ready (i_req.ready),
        .o_cmd   (w_cmd)
    );

    dqvr_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_kind       (i_req.kind),
        .i_value      (i_req.value),
        .i_read_count (i_req.read_count),
        .i_out_ready  (o_rsp.ready),
        .o_rsp        (w_rsp),
        .o_out_valid  (w_out_valid)
    );

    assign o_rsp.valid       = w_out_valid;
    assign o_rsp.item_value  = w_rsp.item_value;
    assign o_rsp.last_of_run = w_rsp.last_of_run;
    assign o_rsp.status      = w_rsp.status;
    assign o_rsp.entry_count = w_rsp.entry_count;

    assign w_in_fire = i_req.valid && i_req.ready;
    assign w_st_err  = o_rsp.valid && (o_rsp.status != ST_OK);
    assign w_st_full = o_rsp.valid && (o_rsp.status == ST_FULL);

    `DQVR_ASSERT_IMPL(a_status_is_last, i_clk, i_rst_n, w_st_err, o_rsp.last_of_run)
    `DQVR_ASSERT_IMPL(a_full_count, i_clk, i_rst_n, w_st_full, o_rsp.entry_count == 7'd64)
    `DQVR_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, o_rsp.valid, o_rsp.entry_count <= 7'd64)
    `DQVR_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, w_in_fire, !i_req.ready)

endmodule
